// ----- src/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants and functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int WordW = 32;

    typedef logic [WordW-1:0] word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       message_end;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_byte;   // write byte_val into the window at block_pos
        logic [7:0] byte_val;
        logic [5:0] block_pos;
        logic       start_comp;  // copy chain value into working registers
        logic       do_round;    // run one round
        logic [5:0] round_idx;
        logic       fold;        // add working registers into chain value
        logic       reinit;      // return chain value to its initial value
        logic [2:0] rd_idx;      // digest word to present
    } dp_cmd_t;

    localparam word_t InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PadByte = 8'h80;

    function automatic word_t round_k(input logic [5:0] r);
        word_t k;
        case (r)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WordW - n));
    endfunction

endpackage

// ----- src/sha256_if.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream interfaces
// Valid/ready channels for input items and digest words.
// ----------------------------------------------------------------------------
interface sha256_in_if;
    import sha256_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

interface sha256_out_if;
    import sha256_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

// ----- src/sha256_datapath.sv -----
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Message schedule window, working registers, one round per cycle, chain value.
// ----------------------------------------------------------------------------
module sha256_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha256_pkg::dp_cmd_t   cmd,
    output sha256_pkg::word_t     digest
);
    import sha256_pkg::*;

    word_t chain_reg [8];
    word_t work_reg  [8];
    word_t win_reg   [16];

    word_t w_cur, w2, w15, s0, s1, t1, t2, a, e;
    logic [3:0] widx;
    logic [4:0] sh;

    assign a = work_reg[0];
    assign e = work_reg[4];
    assign w2  = win_reg[4'(cmd.round_idx - 6'd2)];
    assign w15 = win_reg[4'(cmd.round_idx - 6'd15)];
    assign s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    assign s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);

    always_comb
    begin
        if (cmd.round_idx < 6'd16)
            w_cur = win_reg[cmd.round_idx[3:0]];
        else
            w_cur = s1 + win_reg[4'(cmd.round_idx - 6'd7)] + s0
                  + win_reg[cmd.round_idx[3:0]];
        t1 = work_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
           + ((e & work_reg[5]) ^ (~e & work_reg[6])) + round_k(cmd.round_idx) + w_cur;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
           + ((a & work_reg[1]) ^ (a & work_reg[2]) ^ (work_reg[1] & work_reg[2]));
    end

    assign widx = cmd.block_pos[5:2];
    assign sh   = {~cmd.block_pos[1:0], 3'b000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 8; i++) chain_reg[i] <= InitHash[i];
        end else if (cmd.reinit) begin
            for (int i = 0; i < 8; i++) chain_reg[i] <= InitHash[i];
        end else if (cmd.fold) begin
            for (int i = 0; i < 8; i++) chain_reg[i] <= chain_reg[i] + work_reg[i];
        end
    end

    // The window is always written before it is read, so it needs no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load_byte) begin
            if (cmd.block_pos[1:0] == 2'd0)
                win_reg[widx] <= word_t'(cmd.byte_val) << sh;
            else
                win_reg[widx] <= win_reg[widx] | (word_t'(cmd.byte_val) << sh);
        end else if (cmd.do_round) begin
            win_reg[cmd.round_idx[3:0]] <= w_cur;
        end
        if (cmd.start_comp) begin
            for (int i = 0; i < 8; i++) work_reg[i] <= chain_reg[i];
        end else if (cmd.do_round) begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    assign digest = chain_reg[cmd.rd_idx];

endmodule

// ----- src/sha256_ctrl.sv -----
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte loading, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  sha256_pkg::in_item_t in_item,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           out_idx,
    output sha256_pkg::dp_cmd_t  cmd
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_START, ST_ROUND, ST_FOLD, ST_PAD, ST_EMIT
    } state_t;

    state_t      state_reg;
    logic [5:0]  pos_reg;
    logic [60:0] count_reg;
    logic [5:0]  round_reg;
    logic        pend_end_reg;  // message end waiting after a byte compression
    logic        marker_reg;    // the 0x80 marker byte has been written
    logic        len_here_reg;  // the current block carries the bit length
    logic [2:0]  widx_reg;
    logic [63:0] bits;
    logic [7:0]  pad_byte;
    logic        accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign bits     = {count_reg, 3'b000};
    assign out_valid = (state_reg == ST_EMIT);
    assign out_idx   = widx_reg;

    // Padding writes the marker first, then zeros, and the big-endian bit
    // length in the last eight bytes of the block that has room for it.
    always_comb
    begin
        if (!marker_reg)
            pad_byte = PadByte;
        else if (len_here_reg && pos_reg >= 6'd56)
            pad_byte = bits[{~pos_reg[2:0], 3'b111} -: 8];
        else
            pad_byte = 8'h00;
    end

    always_comb
    begin
        cmd = '0;
        cmd.block_pos = pos_reg;
        cmd.round_idx = round_reg;
        cmd.rd_idx    = widx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load_byte = accept && in_item.byte_valid;
                cmd.byte_val  = in_item.data_byte;
            end
            ST_PAD:
            begin
                cmd.load_byte = 1'b1;
                cmd.byte_val  = pad_byte;
            end
            ST_START: cmd.start_comp = 1'b1;
            ST_ROUND: cmd.do_round = 1'b1;
            ST_FOLD:  cmd.fold = 1'b1;
            ST_EMIT:  cmd.reinit = out_ready && (widx_reg == 3'd7);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            count_reg    <= '0;
            round_reg    <= '0;
            pend_end_reg <= 1'b0;
            marker_reg   <= 1'b0;
            len_here_reg <= 1'b0;
            widx_reg     <= '0;
        end else begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept) begin
                        pend_end_reg <= in_item.message_end;
                        marker_reg   <= 1'b0;
                        len_here_reg <= 1'b0;
                        if (in_item.byte_valid) begin
                            pos_reg   <= pos_reg + 6'd1;
                            count_reg <= count_reg + 61'd1;
                            if (pos_reg == 6'd63)
                                state_reg <= ST_START;
                            else if (in_item.message_end)
                                state_reg <= ST_PAD;
                        end else if (in_item.message_end) begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    pos_reg <= pos_reg + 6'd1;
                    if (!marker_reg) begin
                        // The length fits behind the marker only below offset 56.
                        marker_reg   <= 1'b1;
                        len_here_reg <= (pos_reg < 6'd56);
                    end
                    if (pos_reg == 6'd63)
                        state_reg <= ST_START;
                end
                ST_START:
                begin
                    round_reg <= '0;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                        state_reg <= ST_FOLD;
                end
                ST_FOLD:
                begin
                    if (pend_end_reg && len_here_reg) begin
                        state_reg <= ST_EMIT;
                    end else if (pend_end_reg) begin
                        // The marker did not leave room for the length, so a
                        // further block of zeros and the length follows.
                        if (marker_reg)
                            len_here_reg <= 1'b1;
                        state_reg <= ST_PAD;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT:
                begin
                    if (out_ready) begin
                        widx_reg <= widx_reg + 3'd1;
                        if (widx_reg == 3'd7) begin
                            state_reg    <= ST_IDLE;
                            pos_reg      <= '0;
                            count_reg    <= '0;
                            pend_end_reg <= 1'b0;
                            marker_reg   <= 1'b0;
                            len_here_reg <= 1'b0;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- src/sha256_message_hasher_unit.sv -----
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Streams bytes, pads the message and emits the 256-bit digest as eight words.
// ----------------------------------------------------------------------------
//  Channel | Role   | Beat payload
//  in_ch   | sink   | data_byte[7:0], byte_valid, message_end
//  out_ch  | source | digest_word[31:0], word_index[2:0], last_word
//
// in_ch.ready is high whenever the unit is idle.
// The 64th byte of a block drops ready while the working registers are loaded,
// the rounds run and the working registers are folded into the chain value.
// An end beat pads one byte per cycle to the end of the block and compresses;
// a marker at offset 56 or later adds a second padded block.
// The eight digest beats go out one per cycle while out_ch.ready is high, and
// in_ch stays stalled until the last one is taken. Reset clears all counters
// and restores the initial hash value.
// ----------------------------------------------------------------------------
module sha256_message_hasher_unit (
    input  logic        clk,
    input  logic        rst_n,
    sha256_in_if.sink   in_ch,
    sha256_out_if.source out_ch
);
    import sha256_pkg::*;

    dp_cmd_t    cmd;
    word_t      digest;
    logic [2:0] out_idx;

    // The controller owns the handshakes and every counter; the datapath only
    // follows its commands.
    sha256_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_item   (in_ch.data),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_idx   (out_idx),
        .cmd       (cmd)
    );

    sha256_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .digest (digest)
    );

    // The digest word is read straight from the chain value, which holds
    // still while a beat waits for the receiver.
    assign out_ch.data.digest_word = digest;
    assign out_ch.data.word_index  = out_idx;
    assign out_ch.data.last_word   = (out_idx == 3'd7);

    // A waiting digest beat keeps its payload until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data));

    // Input is never taken while digest words are being sent.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid));

    // The last flag marks the eighth word only.
    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.data.last_word == (out_ch.data.word_index == 3'd7)));

endmodule
